>>> rtl/set_assoc_cache_fifo_lru_top_assert.svh
// assertion macros for the cache tag lookup block
// used by set_assoc_cache_fifo_lru_top; expects clk and rst_n in scope
`ifndef SET_ASSOC_CACHE_FIFO_LRU_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_LRU_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SACFL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SACFL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sacfl_pkg.sv
// shared types and constants of the cache tag lookup block
// no dependencies; used by sacfl_decode and set_assoc_cache_fifo_lru_top
`default_nettype none

package sacfl_pkg;

  // organisation codes
  localparam logic [1:0] ORG_DIRECT   = 2'd0;
  localparam logic [1:0] ORG_FOUR_WAY = 2'd1;
  localparam logic [1:0] ORG_FULL     = 2'd2;

  // replacement codes
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_POLICY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_LOG2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd3;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [3:0] LINES_LOG2_MIN = 4'd2;
  localparam logic [3:0] FOUR_WAY_LOG2  = 4'd2;

  typedef struct packed {
    logic [1:0] org_mode;
    logic       repl_policy;
    logic [3:0] lines_log2;
    logic [3:0] offset_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    org_mode:    ORG_DIRECT,
    repl_policy: POL_LRU,
    lines_log2:  4'd8,
    offset_bits: 4'd4
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sacfl_decode.sv
// address split: set base line, tag and last way of the set for one access
// depends on sacfl_pkg
`default_nettype none

module sacfl_decode #(
  parameter int LMAX      = 8,
  parameter int ADDR_BITS = 32,
  parameter int TAG_W     = (ADDR_BITS < 32) ? ADDR_BITS : 32
) (
  input  sacfl_pkg::cfg_t   cfg,
  input  logic [31:0]       address,
  output logic [LMAX-1:0]   base,
  output logic [TAG_W-1:0]  tag,
  output logic [LMAX-1:0]   last_way
);
  import sacfl_pkg::*;

  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [3:0]  LG_MAX = 4'(LMAX);
  localparam logic [LMAX:0] ONE  = (LMAX+1)'(1);

  logic [3:0]      lg;
  logic [3:0]      way_log;
  logic [3:0]      idx_len;
  logic [4:0]      tag_sh;
  logic [31:0]     addr_m;
  logic [31:0]     set_sh;
  logic [31:0]     tag_full;
  logic [LMAX:0]   set_mask;
  logic [LMAX:0]   way_cnt;
  logic [LMAX-1:0] set_idx;

  // line count clamped to what the store holds
  always_comb begin
    if (cfg.lines_log2 > LG_MAX) begin
      lg = LG_MAX;
    end else if (cfg.lines_log2 < LINES_LOG2_MIN) begin
      lg = LINES_LOG2_MIN;
    end else begin
      lg = cfg.lines_log2;
    end
  end

  // mode three falls into the fully associative arm
  always_comb begin
    unique case (cfg.org_mode)
      ORG_DIRECT: begin
        way_log = 4'd0;
        idx_len = lg;
      end
      ORG_FOUR_WAY: begin
        way_log = FOUR_WAY_LOG2;
        idx_len = lg - FOUR_WAY_LOG2;
      end
      default: begin
        way_log = lg;
        idx_len = 4'd0;
      end
    endcase
  end

  assign addr_m   = address & ADDR_MASK;
  assign set_sh   = addr_m >> cfg.offset_bits;
  assign set_mask = (ONE << idx_len) - ONE;
  assign set_idx  = set_sh[LMAX-1:0] & set_mask[LMAX-1:0];
  assign tag_sh   = {1'b0, cfg.offset_bits} + {1'b0, idx_len};
  assign tag_full = addr_m >> tag_sh;
  assign tag      = tag_full[TAG_W-1:0];
  assign base     = set_idx << way_log;
  assign way_cnt  = ONE << way_log;
  assign last_way = LMAX'(way_cnt - ONE);

endmodule

`default_nettype wire

>>> rtl/set_assoc_cache_fifo_lru_top.sv
// cache tag lookup with fifo or lru replacement, top level
// depends on sacfl_pkg, sacfl_decode and set_assoc_cache_fifo_lru_top_assert.svh
//
//   port group  dir  payload                                    handshake
//   in_*        in   tdata[31:0] address                        tvalid/tready
//   out_*       out  tuser[0] hit; tdata way, access_number     tvalid/tready
//   cfg_*       in   index[1:0], data[3:0]                      valid/ready
//
// after reset the tag store is swept once to mark every line invalid:
//   all 2**floor(log2(TOTAL_LINES)) lines (256 at the default), no item taken then
// one item passes through these steps: the accept, one tag/stamp read per way of
//   the set, registered read data compared as it returns, the write-back and the
//   result; a hit ends the walk at the matching way
// the next item is taken while a result waits in the output register; an item
//   reaching its result cycle with that register still full waits there
// configuration writes are always taken
`default_nettype none
`include "set_assoc_cache_fifo_lru_top_assert.svh"

module set_assoc_cache_fifo_lru_top #(
  parameter int TOTAL_LINES = 256,
  parameter int ADDR_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sacfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacfl_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [31:0]                          in_tdata,   // [31:0] address
  // result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [39:0]                          out_tdata,  // [7:0] way, [39:8] access_number
  output logic [0:0]                           out_tuser   // [0] hit
);
  import sacfl_pkg::*;

  localparam int LMAX   = $clog2(TOTAL_LINES + 1) - 1;  // floor(log2)
  localparam int NLINES = 1 << LMAX;
  localparam int TAG_W  = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef logic [LMAX-1:0] line_t;

  // config registers
  cfg_t cfg_r;

  // control
  state_t state_r, state_nxt;
  line_t  clr_r;

  // one counter serves both stamps and access numbers: it starts at zero and
  // advances once per item; the stamp is the value before the advance, the access number the value after it
  logic [31:0] cnt_r;

  // per-item context
  line_t            base_r;
  logic [TAG_W-1:0] tag_r;
  line_t            last_r;
  logic             lru_r;

  // walk state
  line_t        i_r;        // way whose read is issued
  logic         iss_act_r;
  logic         cv_r;       // read data valid for way cw_r
  line_t        cw_r;
  logic         hit_r;
  line_t        found_r;
  logic         inv_r;
  line_t        inv_w_r;
  logic [31:0]  min_r;
  line_t        min_w_r;
  line_t        way_r;

  // output register
  logic         out_valid_r;
  logic         out_hit_r;
  logic [7:0]   out_way_r;
  logic [31:0]  out_num_r;

  // memories
  logic [TAG_W:0] tag_mem [NLINES];    // {valid, tag}
  logic [31:0]    stamp_mem [NLINES];
  logic [TAG_W:0] tag_q_r;
  logic [31:0]    stamp_q_r;

  // decode
  line_t            dec_base;
  logic [TAG_W-1:0] dec_tag;
  line_t            dec_last;

  // comb control
  logic             accept;
  logic             out_load;
  logic             rd_en;
  line_t            raddr;
  logic             tag_we;
  line_t            tag_waddr;
  logic [TAG_W:0]   tag_wdata;
  logic             st_we;
  line_t            upd_line;
  line_t            res_way;
  logic             hit_now;
  logic             scan_end;

  sacfl_decode #(
    .LMAX      (LMAX),
    .ADDR_BITS (ADDR_BITS),
    .TAG_W     (TAG_W)
  ) u_decode (
    .cfg      (cfg_r),
    .address  (in_tdata),
    .base     (dec_base),
    .tag      (dec_tag),
    .last_way (dec_last)
  );

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORG_MODE:    cfg_r.org_mode    <= cfg_data[1:0];
        REG_REPL_POLICY: cfg_r.repl_policy <= cfg_data[0];
        REG_LINES_LOG2:  cfg_r.lines_log2  <= cfg_data;
        REG_OFFSET_BITS: cfg_r.offset_bits <= cfg_data;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- walk compare
  // data on the memory outputs belongs to way cw_r when cv_r is set
  assign hit_now  = cv_r && tag_q_r[TAG_W] && (tag_q_r[TAG_W-1:0] == tag_r);
  assign scan_end = cv_r && (hit_now || (cw_r == last_r));

  // victim: first invalid way, else oldest stamp (lowest way on ties)
  assign res_way  = hit_r ? found_r : (inv_r ? inv_w_r : min_w_r);
  assign upd_line = base_r + res_way;

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == line_t'(NLINES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_end) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    rd_en     = 1'b0;
    raddr     = base_r + i_r;
    tag_we    = 1'b0;
    tag_waddr = upd_line;
    tag_wdata = {1'b1, tag_r};
    st_we     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_r;
        tag_wdata = '0;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SCAN: begin
        rd_en = iss_act_r;
      end
      ST_UPDATE: begin
        tag_we = !hit_r;
        st_we  = !hit_r || lru_r;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (rd_en) begin
      tag_q_r <= tag_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stamp_mem[upd_line] <= cnt_r;
    end
    if (rd_en) begin
      stamp_q_r <= stamp_mem[raddr];
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      cnt_r       <= '0;
      iss_act_r   <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + line_t'(1);
      end
      if (accept) begin
        iss_act_r <= 1'b1;
        cv_r      <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (scan_end) begin
          iss_act_r <= 1'b0;
          cv_r      <= 1'b0;
        end else begin
          if (iss_act_r && (i_r == last_r)) begin
            iss_act_r <= 1'b0;
          end
          cv_r <= iss_act_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_r + 32'd1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r <= dec_base;
      tag_r  <= dec_tag;
      last_r <= dec_last;
      lru_r  <= (cfg_r.repl_policy == POL_LRU);
      i_r    <= '0;
      hit_r  <= 1'b0;
      inv_r  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (iss_act_r) begin
        i_r <= i_r + line_t'(1);
      end
      cw_r <= i_r;
      if (hit_now) begin
        hit_r   <= 1'b1;
        found_r <= cw_r;
      end else if (cv_r) begin
        if (!tag_q_r[TAG_W] && !inv_r) begin
          inv_r   <= 1'b1;
          inv_w_r <= cw_r;
        end
        if ((cw_r == '0) || (stamp_q_r < min_r)) begin
          min_r   <= stamp_q_r;
          min_w_r <= cw_r;
        end
      end
    end
    if (state_r == ST_UPDATE) begin
      way_r <= res_way;
    end
    if (out_load) begin
      out_hit_r <= hit_r;
      out_way_r <= 8'(way_r);
      out_num_r <= cnt_r + 32'd1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_num_r, out_way_r};
  assign out_tuser  = out_hit_r;

  // ---------------------------------------------------------------- checks
  // the walk never looks past the last way of the set
  `SACFL_ASSERT_IMP(a_walk_in_set, (state_r == ST_SCAN) && cv_r, cw_r <= last_r,
    "walk data beyond last way")
  // the tag store is written only by the clearing sweep or the write-back
  `SACFL_ASSERT_IMP(a_tag_write_phase, tag_we,
    (state_r == ST_CLEAR) || (state_r == ST_UPDATE), "tag store written out of phase")
  // the result way lies within the set
  `SACFL_ASSERT_IMP(a_way_in_set, state_r == ST_UPDATE, res_way <= last_r,
    "result way outside the set")
  // a shown result carries the count of items finished so far
  `SACFL_ASSERT_IMP(a_num_matches, out_valid_r, out_num_r == cnt_r,
    "access number out of step with counter")
  // the write-back is always followed by the result cycle
  `SACFL_ASSERT_NXT(a_update_done, state_r == ST_UPDATE, state_r == ST_DONE,
    "write-back not followed by result")

endmodule

`default_nettype wire

>>> tb/sv/set_assoc_cache_fifo_lru_top_test.sv
// self-checking testbench for the cache tag lookup block: drives byte addresses and
// config writes, predicts hit, way and access count per item, compares every result
// depends on sacfl_pkg and set_assoc_cache_fifo_lru_top
`timescale 1ns / 100ps

module set_assoc_cache_fifo_lru_top_test;
  import sacfl_pkg::*;

  localparam int          TOTAL_LINES    = 256;
  localparam int          ADDR_BITS      = 32;
  localparam int unsigned LINES_LOG2_MAX = $clog2(TOTAL_LINES + 1) - 1;
  // worst run: every item walking 256 ways plus sender gaps and receiver stalls,
  // taken several times over
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int          N_PHASES       = 9;
  localparam int          N_ROWS         = 36;

  // one result item as the block reports it
  typedef struct packed {
    logic        hit;
    logic [7:0]  way;
    logic [31:0] access_number;
  } lookup_t;

  typedef enum bit {ROW_ACCESS, ROW_CFG} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // directed step: either a register write or an address, with the result
  // typed in where it is obvious
  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic [31:0]              addr;
    bit                       typed;
    lookup_t                  want;
  } step_row_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [31:0]              in_tdata   = '0;   // [31:0] address
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [39:0]              out_tdata;         // [7:0] way, [39:8] access_number
  logic [0:0]               out_tuser;         // [0] hit

  set_assoc_cache_fifo_lru_top #(
    .TOTAL_LINES(TOTAL_LINES),
    .ADDR_BITS  (ADDR_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the tag store and the registers
  // ---------------------------------------------------------------------------
  logic        line_ok   [TOTAL_LINES];
  logic [31:0] line_tags [TOTAL_LINES];
  logic [31:0] line_age  [TOTAL_LINES];
  logic [31:0] stamp_now    = '0;
  logic [31:0] access_count = '0;
  cfg_t        cfg_m        = CFG_RESET;

  lookup_t     expected_lookups[$];

  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned hits_seen     = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  logic [31:0] hot_base [2];

  initial begin
    for (int i = 0; i < TOTAL_LINES; i++) begin
      line_ok[i]   = 1'b0;
      line_tags[i] = '0;
      line_age[i]  = '0;
    end
  end

  // line count register saturates to the range the store supports
  function automatic int unsigned effective_lines_log2();
    int unsigned lg;
    lg = cfg_m.lines_log2;
    if (lg > LINES_LOG2_MAX) lg = LINES_LOG2_MAX;
    if (lg < LINES_LOG2_MIN) lg = LINES_LOG2_MIN;
    return lg;
  endfunction

  // look one address up in the predicted tag store, updating it as the block would
  function automatic lookup_t lookup_address(input logic [31:0] addr);
    int unsigned lg, way_log, idx_len, nways, set_idx, base, w, ln, lv, victim;
    logic [63:0] a64;
    logic [31:0] tag;
    bit          found_hit, have_free;
    lookup_t     r;
    lg = effective_lines_log2();
    // mode three falls into the fully associative branch
    case (cfg_m.org_mode)
      ORG_DIRECT: begin
        way_log = 0;
        idx_len = lg;
      end
      ORG_FOUR_WAY: begin
        way_log = FOUR_WAY_LOG2;
        idx_len = lg - FOUR_WAY_LOG2;
      end
      default: begin
        way_log = lg;
        idx_len = 0;
      end
    endcase
    nways   = 1 << way_log;
    a64     = {32'b0, addr};
    set_idx = 32'((a64 >> cfg_m.offset_bits) & ((64'd1 << idx_len) - 64'd1));
    tag     = 32'(a64 >> (cfg_m.offset_bits + idx_len));
    base    = (set_idx << way_log) % TOTAL_LINES;
    access_count++;

    found_hit = 1'b0;
    victim    = 0;
    for (w = 0; w < nways && !found_hit; w++) begin
      ln = (base + w) % TOTAL_LINES;
      if (line_ok[ln] && line_tags[ln] == tag) begin
        // lru refreshes the age on a hit, fifo keeps the fill age
        if (cfg_m.repl_policy == POL_LRU) line_age[ln] = stamp_now;
        found_hit = 1'b1;
        victim    = w;
      end
    end

    if (!found_hit) begin
      have_free = 1'b0;
      for (w = 0; w < nways && !have_free; w++) begin
        ln = (base + w) % TOTAL_LINES;
        if (!line_ok[ln]) begin
          victim    = w;
          have_free = 1'b1;
        end
      end
      // all ways valid: oldest stamp wins, lowest way on ties
      if (!have_free) begin
        for (w = 1; w < nways; w++) begin
          ln = (base + w) % TOTAL_LINES;
          lv = (base + victim) % TOTAL_LINES;
          if (line_age[ln] < line_age[lv]) victim = w;
        end
      end
      ln = (base + victim) % TOTAL_LINES;
      line_ok[ln]   = 1'b1;
      line_tags[ln] = tag;
      line_age[ln]  = stamp_now;
    end
    stamp_now++;

    r.hit           = found_hit;
    r.way           = victim[7:0];
    r.access_number = access_count;
    return r;
  endfunction

  // mostly addresses from a small working set so that hits and evictions occur,
  // the rest fully random so every address bit toggles
  function automatic logic [31:0] pick_address();
    logic [63:0] a;
    int unsigned span;
    if ($urandom_range(0, 99) < 30) return $urandom();
    span = 2 << effective_lines_log2();
    a = {32'b0, hot_base[$urandom_range(0, 1)]};
    a += 64'($urandom_range(0, span - 1)) << cfg_m.offset_bits;
    a += 64'($urandom()) & ((64'd1 << cfg_m.offset_bits) - 64'd1);
    return a[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // drivers; all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // leaves cfg_valid high so back-to-back writes need no re-raise
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORG_MODE:    cfg_m.org_mode    = val[1:0];
      REG_REPL_POLICY: cfg_m.repl_policy = val[0];
      REG_LINES_LOG2:  cfg_m.lines_log2  = val;
      default:         cfg_m.offset_bits = val;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] org, input logic [3:0] pol,
                            input logic [3:0] lines, input logic [3:0] off);
    write_reg(REG_ORG_MODE, org);
    write_reg(REG_REPL_POLICY, pol);
    write_reg(REG_LINES_LOG2, lines);
    write_reg(REG_OFFSET_BITS, off);
    cfg_valid <= 1'b0;
  endtask

  // offer one address; tvalid stays high on return so the next item follows
  // without a gap unless the idle draw says otherwise
  task automatic push_address(input logic [31:0] addr, input bit use_typed = 1'b0,
                              input lookup_t typed_want = '0);
    lookup_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = lookup_address(addr);
    expected_lookups.push_back(use_typed ? typed_want : want);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(negedge clk);
  endtask

  task automatic apply_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      IDLE_BOTH: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // receiver ready: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker: oldest expectation against each accepted result item
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[0]) hits_seen++;
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected: hit %0d way %0d num %0d",
                                  out_tuser[0], out_tdata[7:0], out_tdata[39:8]));
      end else begin
        want = expected_lookups.pop_front();
        if (out_tuser[0] !== want.hit)
          report_mismatch($sformatf("item %0d: hit %0d, expected %0d",
                                    want.access_number, out_tuser[0], want.hit));
        if (out_tdata[7:0] !== want.way)
          report_mismatch($sformatf("item %0d: way %0d, expected %0d",
                                    want.access_number, out_tdata[7:0], want.way));
        if (out_tdata[39:8] !== want.access_number)
          report_mismatch($sformatf("access number %0d, expected %0d",
                                    out_tdata[39:8], want.access_number));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_lookups.size());
      $display("set_assoc_cache_fifo_lru_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed steps; starts under the reset setting (direct-mapped, lru,
  // 256 lines, 16-byte blocks)
  // ---------------------------------------------------------------------------
  localparam step_row_t DIRECTED [N_ROWS] = '{
    // cold miss, then hits on the same block, address extremes
    '{ROW_ACCESS, '0, '0, 32'h0000_0000, 1'b1, '{1'b0, 8'd0, 32'd1}},
    '{ROW_ACCESS, '0, '0, 32'h0000_0000, 1'b1, '{1'b1, 8'd0, 32'd2}},
    '{ROW_ACCESS, '0, '0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 8'd0, 32'd3}},
    '{ROW_ACCESS, '0, '0, 32'hFFFF_FFF0, 1'b1, '{1'b1, 8'd0, 32'd4}},
    '{ROW_ACCESS, '0, '0, 32'h0000_000F, 1'b1, '{1'b1, 8'd0, 32'd5}},
    // conflict on set zero, direct-mapped always evicts way 0
    '{ROW_ACCESS, '0, '0, 32'h0000_1000, 1'b1, '{1'b0, 8'd0, 32'd6}},
    '{ROW_ACCESS, '0, '0, 32'h0000_0000, 1'b1, '{1'b0, 8'd0, 32'd7}},
    '{ROW_ACCESS, '0, '0, 32'h0000_1000, 1'b1, '{1'b0, 8'd0, 32'd8}},
    // mode three, line count below range, large offset; old lines reinterpreted
    '{ROW_CFG, REG_ORG_MODE,    4'd3,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_LINES_LOG2,  4'd0,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_BITS, 4'd15, 32'h0, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_8000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0001_0000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0001_8000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0002_0000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_8000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0002_8000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_8000, 1'b0, '0},
    // fifo, four-way, line count above range, no offset
    '{ROW_CFG, REG_REPL_POLICY, 4'd0,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_ORG_MODE,    4'd1,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_LINES_LOG2,  4'd15, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_BITS, 4'd0,  32'h0, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_0040, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_0080, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_00C0, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_0100, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h7FFF_FFFF, 1'b0, '0},
    // fully associative over all 256 lines, lru, 4 KiB blocks
    '{ROW_CFG, REG_ORG_MODE,    4'd2,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_LINES_LOG2,  4'd8,  32'h0, 1'b0, '0},
    '{ROW_CFG, REG_OFFSET_BITS, 4'd12, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_REPL_POLICY, 4'd1,  32'h0, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACCESS, '0, '0, 32'h8000_0FFF, 1'b0, '0}
  };

  // random phases: setting, item count and idle pattern; the last one draws its
  // setting at random and changes idle pattern every few dozen items
  logic [3:0] phase_org   [N_PHASES] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd1, 4'd0, 4'd3, 4'd2, 4'd0};
  logic [3:0] phase_pol   [N_PHASES] = '{4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd0};
  logic [3:0] phase_lines [N_PHASES] = '{4'd8, 4'd4, 4'd3, 4'd5, 4'd2, 4'd15, 4'd0, 4'd8, 4'd0};
  logic [3:0] phase_off   [N_PHASES] = '{4'd4, 4'd2, 4'd0, 4'd6, 4'd12, 4'd15, 4'd13, 4'd1, 4'd0};
  int         phase_items [N_PHASES] = '{150, 150, 150, 150, 100, 100, 100, 40, 185};
  idle_mode_t phase_idle  [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                         IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_RECV,
                                         IDLE_NONE};

  initial begin
    bit prev_cfg;
    prev_cfg = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling on either side
    apply_idle(IDLE_NONE);
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        if (!prev_cfg) drain_results();
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        push_address(DIRECTED[r].addr, DIRECTED[r].typed, DIRECTED[r].want);
        prev_cfg = 1'b0;
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      if (p == N_PHASES - 1)
        set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      else
        set_config(phase_org[p], phase_pol[p], phase_lines[p], phase_off[p]);
      hot_base[0] = $urandom();
      hot_base[1] = $urandom();
      apply_idle(phase_idle[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        // long receiver hold-off while items keep coming: block backs up
        if (p == 0 && i == 50) hold_req = 400;
        // sender waits for the pipeline to empty mid-phase
        if (p == 1 && i == 75) drain_results();
        if (p == N_PHASES - 1 && i % 40 == 0)
          apply_idle(idle_mode_t'($urandom_range(0, 3)));
        push_address(pick_address());
      end
    end

    drain_results();
    repeat (300) @(posedge clk);

    $display("covered %0d lookups (%0d hits) over direct, four-way, full and mode three,",
             results_seen, hits_seen);
    $display("fifo and lru, saturated line counts, offsets 0..15 and reconfiguration");
    if (error_count == 0) begin
      $display("set_assoc_cache_fifo_lru_top: match");
    end else begin
      $display("set_assoc_cache_fifo_lru_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sacfl_pkg.sv
rtl/sacfl_decode.sv
rtl/set_assoc_cache_fifo_lru_top.sv
tb/sv/set_assoc_cache_fifo_lru_top_test.sv
